// ===== sv/btr_pkg.sv =====
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and the glyph ROM of the bitmap text rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package btr_pkg;

    // Font geometry
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int FONT_SIZE   = 28;
    localparam int GLYPH_IDX_W = $clog2(FONT_SIZE);
    localparam int ROW_W       = 3;
    localparam int WIDTH_W     = 3;

    // Field widths
    localparam int CODE_W      = 8;
    localparam int COORD_W     = 16;
    localparam int COORD_BITS  = 16;
    localparam int PIX_W       = 6;
    localparam int COLOR_W     = 32;
    localparam int ADV_W       = 8;   // (width+1)*pix tops out at 192
    localparam int OFF_W       = 8;   // col*pix tops out at 128, row*pix at 192

    // Pixel size limits and reset values
    localparam logic [PIX_W-1:0]   PIX_MIN     = 6'd1;
    localparam logic [PIX_W-1:0]   PIX_MAX     = 6'd32;
    localparam logic [PIX_W-1:0]   PIX_RESET   = 6'd2;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;
    localparam logic [WIDTH_W-1:0] SPACE_CELLS = 3'd4;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b1;

    // Result kinds
    localparam logic ITEM_SQUARE = 1'b0;
    localparam logic ITEM_DONE   = 1'b1;

    // Row 0 sits in the top bits, each row right-aligned to the glyph width
    typedef logic [GLYPH_ROWS*GLYPH_COLS-1:0] glyph_bits_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        glyph_bits_t        bits;
    } glyph_t;

    typedef struct packed {
        logic                   known;
        logic [GLYPH_IDX_W-1:0] idx;
    } glyph_sel_t;

    // One character handed from front to back
    typedef struct packed {
        logic                   known;
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [COORD_W-1:0]     x_base;    // start_x + pen offset, saturated
        logic [COORD_W-1:0]     y_base;    // start_y
        logic [COORD_W-1:0]     pen_after;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } back_state_t;

    // Character byte to font index; space and everything else is unknown
    function automatic glyph_sel_t glyph_lookup(input logic [CODE_W-1:0] code);
        glyph_sel_t s;
        s.known = 1'b1;
        case (code)
            8'h43:   s.idx = 5'd0;   // C
            8'h49:   s.idx = 5'd1;   // I
            8'h4C:   s.idx = 5'd2;   // L
            8'h4D:   s.idx = 5'd3;   // M
            8'h4F:   s.idx = 5'd4;   // O
            8'h50:   s.idx = 5'd5;   // P
            8'h53:   s.idx = 5'd6;   // S
            8'h54:   s.idx = 5'd7;   // T
            8'h59:   s.idx = 5'd8;   // Y
            8'h63:   s.idx = 5'd9;   // c
            8'h65:   s.idx = 5'd10;  // e
            8'h67:   s.idx = 5'd11;  // g
            8'h68:   s.idx = 5'd12;  // h
            8'h69:   s.idx = 5'd13;  // i
            8'h6A:   s.idx = 5'd14;  // j
            8'h6E:   s.idx = 5'd15;  // n
            8'h6F:   s.idx = 5'd16;  // o
            8'h70:   s.idx = 5'd17;  // p
            8'h72:   s.idx = 5'd18;  // r
            8'h73:   s.idx = 5'd19;  // s
            8'h74:   s.idx = 5'd20;  // t
            8'h79:   s.idx = 5'd21;  // y
            8'h30:   s.idx = 5'd22;  // 0
            8'h32:   s.idx = 5'd23;  // 2
            8'h36:   s.idx = 5'd24;  // 6
            8'h2D:   s.idx = 5'd25;  // -
            8'h28:   s.idx = 5'd26;  // (
            8'h29:   s.idx = 5'd27;  // )
            default:
            begin
                s.known = 1'b0;
                s.idx   = '0;
            end
        endcase
        return s;
    endfunction

    // Glyph ROM: width, then rows top to bottom
    function automatic glyph_t glyph_rom(input logic [GLYPH_IDX_W-1:0] idx);
        glyph_t g;
        case (idx)
            5'd0:  g = {3'd5, 5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            5'd1:  g = {3'd3, 5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h07};
            5'd2:  g = {3'd5, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            5'd3:  g = {3'd5, 5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            5'd4:  g = {3'd5, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            5'd5:  g = {3'd5, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            5'd6:  g = {3'd5, 5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            5'd7:  g = {3'd5, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            5'd8:  g = {3'd5, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            5'd9:  g = {3'd5, 5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
            5'd10: g = {3'd5, 5'h00, 5'h00, 5'h0E, 5'h11, 5'h1E, 5'h10, 5'h0F};
            5'd11: g = {3'd5, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h1E};
            5'd12: g = {3'd5, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
            5'd13: g = {3'd1, 5'h01, 5'h00, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01};
            5'd14: g = {3'd3, 5'h01, 5'h00, 5'h01, 5'h01, 5'h01, 5'h05, 5'h02};
            5'd15: g = {3'd5, 5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
            5'd16: g = {3'd5, 5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            5'd17: g = {3'd5, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10};
            5'd18: g = {3'd5, 5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
            5'd19: g = {3'd5, 5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
            5'd20: g = {3'd5, 5'h08, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h09, 5'h06};
            5'd21: g = {3'd5, 5'h00, 5'h00, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h1E};
            5'd22: g = {3'd5, 5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            5'd23: g = {3'd5, 5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            5'd24: g = {3'd5, 5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            5'd25: g = {3'd5, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            5'd26: g = {3'd2, 5'h01, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h01};
            5'd27: g = {3'd2, 5'h02, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h02};
            default: g = '0;
        endcase
        return g;
    endfunction

    // One row of a glyph, shifted so that column 0 lands on the top bit
    function automatic logic [GLYPH_COLS-1:0] glyph_row_mask(
        input glyph_bits_t        bits,
        input logic [ROW_W-1:0]   row,
        input logic [WIDTH_W-1:0] width
    );
        logic [GLYPH_COLS-1:0] raw;
        raw = '0;
        if (int'(row) < GLYPH_ROWS)
        begin
            raw = bits[(GLYPH_ROWS - 1 - int'(row)) * GLYPH_COLS +: GLYPH_COLS];
        end
        return GLYPH_COLS'(raw << (WIDTH_W'(GLYPH_COLS) - width));
    endfunction

endpackage

`default_nettype wire

// ===== sv/btr_char_if.sv =====
// ----------------------------------------------------------------------------
// btr_char_if
// Character channel: one character byte plus optional string origin.
// ----------------------------------------------------------------------------
`default_nettype none

interface btr_char_if;
    logic                         valid;
    logic                         ready;
    logic [btr_pkg::CODE_W-1:0]   char_code;
    logic                         first_of_string;
    logic [btr_pkg::COORD_W-1:0]  origin_x;
    logic [btr_pkg::COORD_W-1:0]  origin_y;

    modport source (
        output valid, char_code, first_of_string, origin_x, origin_y,
        input  ready
    );

    modport sink (
        input  valid, char_code, first_of_string, origin_x, origin_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/btr_item_if.sv =====
// ----------------------------------------------------------------------------
// btr_item_if
// Result channel: filled squares and per-character done items.
// ----------------------------------------------------------------------------
`default_nettype none

interface btr_item_if;
    logic                         valid;
    logic                         ready;
    logic                         item_kind;
    logic [btr_pkg::COORD_W-1:0]  square_x;
    logic [btr_pkg::COORD_W-1:0]  square_y;
    logic [btr_pkg::PIX_W-1:0]    square_edge;
    logic [btr_pkg::COLOR_W-1:0]  square_color;
    logic [btr_pkg::COORD_W-1:0]  pen_offset_after;
    logic                         last_of_run;

    modport source (
        output valid, item_kind, square_x, square_y, square_edge, square_color,
               pen_offset_after, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, item_kind, square_x, square_y, square_edge, square_color,
               pen_offset_after, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/btr_front.sv =====
// ----------------------------------------------------------------------------
// btr_front
// Accepts characters, looks up the glyph, tracks origin and pen offset and
// queues one job per character for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module btr_front #(
    parameter int COORD_BITS = btr_pkg::COORD_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    btr_char_if.sink                          chars,
    input  wire logic [btr_pkg::PIX_W-1:0]    pix,
    input  wire logic                         full,
    output      logic                         push,
    output      btr_pkg::job_t                push_job
);

    localparam int CW  = btr_pkg::COORD_W;
    localparam int AW  = btr_pkg::ADV_W;
    localparam logic [CW:0] ORIGIN_LIMIT = (CW+1)'((1 << COORD_BITS) - 1);
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [COORD_BITS-1:0] pen_reg,     pen_next;

    btr_pkg::glyph_sel_t           sel;
    btr_pkg::glyph_t               glyph;
    logic [btr_pkg::WIDTH_W-1:0]   cells;
    logic [AW-1:0]                 advance;
    logic [COORD_BITS-1:0]         pen_base;
    logic [COORD_BITS:0]           pen_sum;
    logic [COORD_BITS:0]           x_sum;
    logic [COORD_BITS-1:0]         x_base;

    // Handshake: take a character whenever the queue has room
    assign chars.ready = !full;
    assign push        = chars.valid && !full;

    // Glyph lookup and advance
    always_comb
    begin
        sel     = btr_pkg::glyph_lookup(chars.char_code);
        glyph   = btr_pkg::glyph_rom(sel.idx);
        cells   = sel.known ? (glyph.width + 3'd1) : btr_pkg::SPACE_CELLS;
        advance = AW'(AW'(cells) * AW'(pix));
    end

    // Origin load and pen offset update, both saturating
    always_comb
    begin
        if (chars.first_of_string)
        begin
            start_x_next = ({1'b0, chars.origin_x} > ORIGIN_LIMIT)
                         ? COORD_MAX : COORD_BITS'(chars.origin_x);
            start_y_next = ({1'b0, chars.origin_y} > ORIGIN_LIMIT)
                         ? COORD_MAX : COORD_BITS'(chars.origin_y);
            pen_base     = '0;
        end
        else
        begin
            start_x_next = start_x_reg;
            start_y_next = start_y_reg;
            pen_base     = pen_reg;
        end

        pen_sum  = {1'b0, pen_base} + (COORD_BITS+1)'(advance);
        pen_next = pen_sum[COORD_BITS] ? COORD_MAX : pen_sum[COORD_BITS-1:0];

        x_sum    = {1'b0, start_x_next} + {1'b0, pen_base};
        x_base   = x_sum[COORD_BITS] ? COORD_MAX : x_sum[COORD_BITS-1:0];
    end

    // Job for the back end
    always_comb
    begin
        push_job.known     = sel.known;
        push_job.glyph     = sel.idx;
        push_job.x_base    = CW'(x_base);
        push_job.y_base    = CW'(start_y_next);
        push_job.pen_after = CW'(pen_next);
    end

    // String state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            pen_reg     <= '0;
        end
        else if (push)
        begin
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            pen_reg     <= pen_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/btr_queue.sv =====
// ----------------------------------------------------------------------------
// btr_queue
// Small job FIFO that decouples character intake from square emission.
// ----------------------------------------------------------------------------
`default_nettype none

module btr_queue #(
    parameter int DEPTH = btr_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire btr_pkg::job_t   push_job,
    output      logic            full,
    output      logic            not_empty,
    input  wire logic            pop,
    output      btr_pkg::job_t   head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    btr_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = slots_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/btr_back.sv =====
// ----------------------------------------------------------------------------
// btr_back
// Walks the set cells of one glyph, one square per cycle unless the output
// stalls, then emits the done item. Results leave through a registered output
// stage.
`default_nettype none

module btr_back #(
    parameter int COORD_BITS = btr_pkg::COORD_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [btr_pkg::PIX_W-1:0]    pix,
    input  wire logic [btr_pkg::COLOR_W-1:0]  color,
    input  wire logic                         not_empty,
    output      logic                         pop,
    input  wire btr_pkg::job_t                head_job,
    btr_item_if.source                        items
);

    localparam int CW   = btr_pkg::COORD_W;
    localparam int OW   = btr_pkg::OFF_W;
    localparam int NC   = btr_pkg::GLYPH_COLS;
    localparam int RW   = btr_pkg::ROW_W;
    localparam logic [RW-1:0] LAST_ROW = RW'(btr_pkg::GLYPH_ROWS - 1);
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    // Sequencer state
    btr_pkg::back_state_t               state_reg,   state_next;
    logic [btr_pkg::GLYPH_IDX_W-1:0]    glyph_reg,   glyph_next;
    logic [btr_pkg::WIDTH_W-1:0]        width_reg,   width_next;
    logic [RW-1:0]                      row_reg,     row_next;
    logic [NC-1:0]                      mask_reg,    mask_next;
    logic [OW-1:0]                      row_off_reg, row_off_next;
    logic [COORD_BITS-1:0]              x_base_reg,  x_base_next;
    logic [COORD_BITS-1:0]              y_base_reg,  y_base_next;
    logic [CW-1:0]                      pen_reg,     pen_next;

    // Output stage
    logic                               out_valid_reg;
    logic                               out_kind_reg;
    logic [CW-1:0]                      out_x_reg;
    logic [CW-1:0]                      out_y_reg;
    logic [btr_pkg::PIX_W-1:0]          out_edge_reg;
    logic [btr_pkg::COLOR_W-1:0]        out_color_reg;
    logic [CW-1:0]                      out_pen_reg;
    logic                               out_last_reg;

    logic                               slot_free;
    logic                               emit_square;
    logic                               emit_done;
    btr_pkg::glyph_t                    head_glyph;
    btr_pkg::glyph_t                    cur_glyph;
    logic                               found;
    logic [btr_pkg::WIDTH_W-1:0]        col;
    logic [NC-1:0]                      pick;
    logic [NC-1:0]                      mask_left;
    logic [OW-1:0]                      col_off;
    logic [COORD_BITS:0]                x_sum;
    logic [COORD_BITS:0]                y_sum;
    logic [COORD_BITS-1:0]              sq_x;
    logic [COORD_BITS-1:0]              sq_y;

    assign slot_free  = !out_valid_reg || items.ready;
    assign head_glyph = btr_pkg::glyph_rom(head_job.glyph);
    assign cur_glyph  = btr_pkg::glyph_rom(glyph_reg);

    // Leftmost remaining cell of the current row
    always_comb
    begin
        found = 1'b0;
        col   = '0;
        pick  = '0;
        for (int i = NC - 1; i >= 0; i--)
        begin
            if (!found && mask_reg[i])
            begin
                found   = 1'b1;
                col     = btr_pkg::WIDTH_W'(NC - 1 - i);
                pick[i] = 1'b1;
            end
        end
        mask_left = mask_reg & ~pick;
    end

    // Square corner, saturated
    always_comb
    begin
        col_off = OW'(OW'(col) * OW'(pix));
        x_sum   = {1'b0, x_base_reg} + (COORD_BITS+1)'(col_off);
        y_sum   = {1'b0, y_base_reg} + (COORD_BITS+1)'(row_off_reg);
        sq_x    = x_sum[COORD_BITS] ? COORD_MAX : x_sum[COORD_BITS-1:0];
        sq_y    = y_sum[COORD_BITS] ? COORD_MAX : y_sum[COORD_BITS-1:0];
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        glyph_next   = glyph_reg;
        width_next   = width_reg;
        row_next     = row_reg;
        mask_next    = mask_reg;
        row_off_next = row_off_reg;
        x_base_next  = x_base_reg;
        y_base_next  = y_base_reg;
        pen_next     = pen_reg;
        pop          = 1'b0;
        emit_square  = 1'b0;
        emit_done    = 1'b0;

        case (state_reg)
            btr_pkg::BK_IDLE:
            begin
                if (not_empty)
                begin
                    pop          = 1'b1;
                    glyph_next   = head_job.glyph;
                    width_next   = head_glyph.width;
                    row_next     = '0;
                    row_off_next = '0;
                    mask_next    = btr_pkg::glyph_row_mask(head_glyph.bits, '0,
                                                           head_glyph.width);
                    x_base_next  = COORD_BITS'(head_job.x_base);
                    y_base_next  = COORD_BITS'(head_job.y_base);
                    pen_next     = head_job.pen_after;
                    state_next   = head_job.known ? btr_pkg::BK_SCAN
                                                  : btr_pkg::BK_DONE;
                end
            end

            btr_pkg::BK_SCAN:
            begin
                if (found)
                begin
                    if (slot_free)
                    begin
                        emit_square = 1'b1;
                        mask_next   = mask_left;
                    end
                end
                // Row finished (or empty): step to the next one
                if (!found || (slot_free && (mask_left == '0)))
                begin
                    if (row_reg == LAST_ROW)
                    begin
                        state_next = btr_pkg::BK_DONE;
                    end
                    else
                    begin
                        row_next     = row_reg + 1'b1;
                        row_off_next = row_off_reg + OW'(pix);
                        mask_next    = btr_pkg::glyph_row_mask(cur_glyph.bits,
                                                               row_reg + 1'b1,
                                                               width_reg);
                    end
                end
            end

            btr_pkg::BK_DONE:
            begin
                if (slot_free)
                begin
                    emit_done  = 1'b1;
                    state_next = btr_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = btr_pkg::BK_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btr_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg   <= glyph_next;
        width_reg   <= width_next;
        row_reg     <= row_next;
        mask_reg    <= mask_next;
        row_off_reg <= row_off_next;
        x_base_reg  <= x_base_next;
        y_base_reg  <= y_base_next;
        pen_reg     <= pen_next;
    end

    // Output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= emit_square || emit_done;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (emit_square)
        begin
            out_kind_reg  <= btr_pkg::ITEM_SQUARE;
            out_x_reg     <= CW'(sq_x);
            out_y_reg     <= CW'(sq_y);
            out_edge_reg  <= pix;
            out_color_reg <= color;
            out_pen_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (emit_done)
        begin
            out_kind_reg  <= btr_pkg::ITEM_DONE;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_edge_reg  <= '0;
            out_color_reg <= '0;
            out_pen_reg   <= pen_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign items.valid            = out_valid_reg;
    assign items.item_kind        = out_kind_reg;
    assign items.square_x         = out_x_reg;
    assign items.square_y         = out_y_reg;
    assign items.square_edge      = out_edge_reg;
    assign items.square_color     = out_color_reg;
    assign items.pen_offset_after = out_pen_reg;
    assign items.last_of_run      = out_last_reg;

    // Checks
    a_row_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btr_pkg::BK_SCAN) |-> (row_reg <= LAST_ROW))
        else $error("scan row past last glyph row");

    a_mask_in_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btr_pkg::BK_SCAN) |-> (NC'(mask_reg << width_reg) == '0))
        else $error("cell mask outside glyph width");

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (not_empty && (state_reg == btr_pkg::BK_IDLE)))
        else $error("job popped from empty queue or while busy");

    a_square_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == btr_pkg::ITEM_SQUARE))
        |-> ((out_edge_reg >= btr_pkg::PIX_MIN) && (out_edge_reg <= btr_pkg::PIX_MAX)))
        else $error("square edge out of range");

endmodule

`default_nettype wire

// ===== sv/bitmap_text_rasterizer.sv =====
// With the back end idle, an accepted character goes into the job queue, is popped into
// the back-end sequencer registers, and its first result is then registered in the
// output stage. Per character: load the job, one square per set glyph cell, a step over
// each empty row, then the done item (a space or unknown byte gets only that). Throughput:
// one result per cycle over set cells unless the output stalls; a full queue stalls input.
// Reset: pixel_size 2, text_color all ones, origin and pen offset zero, queue empty.
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer
// Character generator for a 7-row bitmap font: intake front, job queue and
// square-emitting back end, plus the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_rasterizer #(
    parameter int COORD_BITS  = btr_pkg::COORD_BITS,
    parameter int QUEUE_DEPTH = btr_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [btr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]    cfg_data,
    btr_char_if.sink                               chars,
    btr_item_if.source                             items
);

    localparam int PW = btr_pkg::PIX_W;

    logic [PW-1:0]                  pixel_size_reg;
    logic [btr_pkg::COLOR_W-1:0]    text_color_reg;
    logic [PW-1:0]                  pix;

    logic                           push;
    logic                           full;
    logic                           not_empty;
    logic                           pop;
    btr_pkg::job_t                  push_job;
    btr_pkg::job_t                  head_job;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_size_reg <= btr_pkg::PIX_RESET;
            text_color_reg <= btr_pkg::COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btr_pkg::CFG_PIXEL_SIZE: pixel_size_reg <= cfg_data[PW-1:0];
                btr_pkg::CFG_TEXT_COLOR: text_color_reg <= cfg_data[btr_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pixel size clamped to 1..32
    always_comb
    begin
        if (pixel_size_reg < btr_pkg::PIX_MIN)
        begin
            pix = btr_pkg::PIX_MIN;
        end
        else if (pixel_size_reg > btr_pkg::PIX_MAX)
        begin
            pix = btr_pkg::PIX_MAX;
        end
        else
        begin
            pix = pixel_size_reg;
        end
    end

    btr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .pix      (pix),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    btr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .head_job  (head_job)
    );

    btr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .color     (text_color_reg),
        .not_empty (not_empty),
        .pop       (pop),
        .head_job  (head_job),
        .items     (items)
    );

endmodule

`default_nettype wire
